// ===== src/fpq_pkg.sv =====
// Shared constants, types and helper functions of the fp32 to uint8 quantizer.
package fpq_pkg;

   localparam int FP_W   = 32;
   localparam int SIG_W  = 24;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS  = 1'b1;

   localparam logic [FP_W-1:0] SCALE_RESET = 32'h3F80_0000;
   localparam logic [FP_W-1:0] BIAS_RESET  = 32'h0000_0000;
   localparam logic [FP_W-1:0] QNAN        = 32'h7FC0_0000;

   typedef struct packed {
      logic en;
      logic valid;
   } stage_ctl_type;

   // normalized operand: sig has its MSB set unless the operand is zero
   typedef struct packed {
      logic              sign;
      logic              nan;
      logic              inf;
      logic              zero;
      logic signed [9:0] exp;
      logic [SIG_W-1:0]  sig;
   } op_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      n = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) n = 5'(23 - i);
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      n = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) n = 5'(26 - i);
      end
      return n;
   endfunction

   function automatic op_type norm_op(input logic [FP_W-1:0] b);
      op_type     o;
      logic [7:0] e;
      logic [7:0] eff;
      logic [23:0] sig;
      logic [4:0] lz;
      e     = b[30:23];
      eff   = (e == 8'd0) ? 8'd1 : e;
      sig   = {e != 8'd0, b[22:0]};
      lz    = lzc24(sig);
      o.sign = b[31];
      o.nan  = (e == 8'hFF) && (b[22:0] != 23'd0);
      o.inf  = (e == 8'hFF) && (b[22:0] == 23'd0);
      o.zero = (b[30:0] == 31'd0);
      o.sig  = sig << lz;
      o.exp  = $signed({2'b00, eff} - {5'd0, lz});
      return o;
   endfunction

endpackage

// ===== src/fpq_mul.sv =====
// Four-stage binary32 multiplier, round to nearest even, full subnormal support.
module fpq_mul import fpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  stage_ctl_type     ctl,
   input  logic [FP_W-1:0]   a_bits,
   input  logic [FP_W-1:0]   b_bits,
   output logic [FP_W-1:0]   prod_bits,
   output logic              out_valid
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] v_ff, v_in;

   // stage 1: unpack and normalize operands
   op_type oa, ob;
   logic               s1_sign_ff, s1_nan_ff, s1_inf_ff, s1_zero_ff;
   logic signed [10:0] s1_exp_ff, s1_exp_in;
   logic [SIG_W-1:0]   s1_siga_ff, s1_sigb_ff;

   // stage 2: product
   logic               s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_zero_ff;
   logic signed [10:0] s2_exp_ff;
   logic [47:0]        s2_prod_ff, s2_prod_in;

   // stage 3: normalize and denormalize shift
   logic [47:0]        pn, shifted;
   logic signed [10:0] e3, diff;
   logic [4:0]         sh;
   logic               lost;
   logic               s3_sign_ff, s3_nan_ff, s3_inf_ff, s3_zero_ff, s3_ovf_ff;
   logic [7:0]         s3_exp_ff;
   logic [23:0]        s3_keep_ff;
   logic               s3_g_ff, s3_st_ff;

   // stage 4: round and pack
   logic [30:0]        field, rnd;
   logic               inc;
   logic [FP_W-1:0]    prod_in;

   assign oa = norm_op(a_bits);
   assign ob = norm_op(b_bits);
   assign s1_exp_in = 11'({oa.exp[9], oa.exp}) + 11'({ob.exp[9], ob.exp}) - 11'sd127;

   assign s2_prod_in = s1_siga_ff * s1_sigb_ff;

   always_comb begin
      pn   = s2_prod_ff[47] ? s2_prod_ff : {s2_prod_ff[46:0], 1'b0};
      e3   = s2_exp_ff + (s2_prod_ff[47] ? 11'sd1 : 11'sd0);
      diff = 11'sd1 - e3;
      if (e3 >= 11'sd1) begin
         sh = 5'd0;
      end else if (diff > 11'sd26) begin
         sh = 5'd26;
      end else begin
         sh = diff[4:0];
      end
      shifted = pn >> sh;
      lost    = |(pn & ~({48{1'b1}} << sh));
   end

   always_comb begin
      field = {s3_keep_ff[23] ? s3_exp_ff : 8'd0, s3_keep_ff[22:0]};
      inc   = s3_g_ff & (s3_st_ff | s3_keep_ff[0]);
      rnd   = field + {30'd0, inc};
      if (s3_nan_ff) begin
         prod_in = QNAN;
      end else if (s3_inf_ff) begin
         prod_in = {s3_sign_ff, 8'hFF, 23'd0};
      end else if (s3_zero_ff) begin
         prod_in = {s3_sign_ff, 31'd0};
      end else if (s3_ovf_ff) begin
         prod_in = {s3_sign_ff, 8'hFF, 23'd0};
      end else begin
         prod_in = {s3_sign_ff, rnd};
      end
   end

   assign v_in = {v_ff[STAGES-2:0], ctl.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ctl.en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         s1_sign_ff <= oa.sign ^ ob.sign;
         s1_nan_ff  <= oa.nan | ob.nan | (oa.inf & ob.zero) | (oa.zero & ob.inf);
         s1_inf_ff  <= oa.inf | ob.inf;
         s1_zero_ff <= oa.zero | ob.zero;
         s1_exp_ff  <= s1_exp_in;
         s1_siga_ff <= oa.sig;
         s1_sigb_ff <= ob.sig;

         s2_sign_ff <= s1_sign_ff;
         s2_nan_ff  <= s1_nan_ff;
         s2_inf_ff  <= s1_inf_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_prod_ff <= s2_prod_in;

         s3_sign_ff <= s2_sign_ff;
         s3_nan_ff  <= s2_nan_ff;
         s3_inf_ff  <= s2_inf_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_ovf_ff  <= e3 >= 11'sd255;
         s3_exp_ff  <= e3[7:0];
         s3_keep_ff <= shifted[47:24];
         s3_g_ff    <= shifted[23];
         s3_st_ff   <= (|shifted[22:0]) | lost;

         prod_bits  <= prod_in;
      end
   end

   assign out_valid = v_ff[STAGES-1];

`ifndef SYNTH
   a_enter: assert property (@(posedge clock) disable iff (reset)
      ctl.valid && ctl.en |=> v_ff[0])
      else $error("accepted word did not enter the multiplier");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.en |=> $stable(v_ff))
      else $error("multiplier valid bits moved while stalled");
   a_shift: assert property (@(posedge clock) disable iff (reset)
      ctl.en |=> v_ff[STAGES-1:1] == $past(v_ff[STAGES-2:0]))
      else $error("multiplier valid bits lost or repeated");
`endif

endmodule

// ===== src/fpq_add.sv =====
// Four-stage binary32 adder, round to nearest even, full subnormal support.
module fpq_add import fpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  stage_ctl_type     ctl,
   input  logic [FP_W-1:0]   a_bits,
   input  logic [FP_W-1:0]   b_bits,
   output logic [FP_W-1:0]   sum_bits,
   output logic              out_valid
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] v_ff, v_in;

   // stage 1: order by magnitude
   logic [FP_W-1:0] big, lit;
   logic            swap, a_nan, b_nan, a_inf, b_inf;
   logic [7:0]      ea, eb;
   logic            s1_sign_ff, s1_sub_ff, s1_nan_ff, s1_inf_ff, s1_isgn_ff;
   logic [7:0]      s1_ea_ff, s1_d_ff;
   logic [23:0]     s1_siga_ff, s1_sigb_ff;

   // stage 2: align and add
   logic [26:0]     bext, bsh, bal, a27;
   logic [4:0]      ash;
   logic            alost;
   logic [27:0]     s2_sum_in;
   logic            s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_isgn_ff;
   logic [7:0]      s2_ea_ff;
   logic [27:0]     s2_sum_ff;

   // stage 3: normalize
   logic [4:0]      lz, shl;
   logic [7:0]      lim;
   logic [26:0]     sn_in;
   logic [8:0]      e_in;
   logic            s3_sign_ff, s3_nan_ff, s3_inf_ff, s3_isgn_ff;
   logic [26:0]     s3_sn_ff;
   logic [8:0]      s3_e_ff;

   // stage 4: round and pack
   logic [23:0]     keep;
   logic [30:0]     field, rnd;
   logic            inc;
   logic [FP_W-1:0] sum_in;

   always_comb begin
      swap  = b_bits[30:0] > a_bits[30:0];
      big   = swap ? b_bits : a_bits;
      lit   = swap ? a_bits : b_bits;
      ea    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb    = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
      a_nan = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] != 23'd0);
      b_nan = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] != 23'd0);
      a_inf = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] == 23'd0);
      b_inf = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] == 23'd0);
   end

   always_comb begin
      bext  = {s1_sigb_ff, 3'b000};
      ash   = (s1_d_ff > 8'd27) ? 5'd27 : s1_d_ff[4:0];
      bsh   = bext >> ash;
      alost = |(bext & ~({27{1'b1}} << ash));
      bal   = {bsh[26:1], bsh[0] | alost};
      a27   = {s1_siga_ff, 3'b000};
      s2_sum_in = s1_sub_ff ? ({1'b0, a27} - {1'b0, bal}) : ({1'b0, a27} + {1'b0, bal});
   end

   always_comb begin
      lz  = lzc27(s2_sum_ff[26:0]);
      lim = s2_ea_ff - 8'd1;
      shl = ({3'd0, lz} > lim) ? lim[4:0] : lz;
      if (s2_sum_ff[27]) begin
         sn_in = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         e_in  = {1'b0, s2_ea_ff} + 9'd1;
      end else begin
         sn_in = s2_sum_ff[26:0] << shl;
         e_in  = {1'b0, s2_ea_ff} - {4'd0, shl};
      end
   end

   always_comb begin
      keep  = s3_sn_ff[26:3];
      field = {keep[23] ? s3_e_ff[7:0] : 8'd0, keep[22:0]};
      inc   = s3_sn_ff[2] & ((|s3_sn_ff[1:0]) | keep[0]);
      rnd   = field + {30'd0, inc};
      if (s3_nan_ff) begin
         sum_in = QNAN;
      end else if (s3_inf_ff) begin
         sum_in = {s3_isgn_ff, 8'hFF, 23'd0};
      end else if (s3_e_ff >= 9'd255) begin
         sum_in = {s3_sign_ff, 8'hFF, 23'd0};
      end else begin
         sum_in = {s3_sign_ff, rnd};
      end
   end

   assign v_in = {v_ff[STAGES-2:0], ctl.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ctl.en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         s1_sign_ff <= big[31];
         s1_sub_ff  <= big[31] ^ lit[31];
         s1_nan_ff  <= a_nan | b_nan | (a_inf & b_inf & (a_bits[31] != b_bits[31]));
         s1_inf_ff  <= a_inf | b_inf;
         s1_isgn_ff <= a_inf ? a_bits[31] : b_bits[31];
         s1_ea_ff   <= ea;
         s1_d_ff    <= ea - eb;
         s1_siga_ff <= {big[30:23] != 8'd0, big[22:0]};
         s1_sigb_ff <= {lit[30:23] != 8'd0, lit[22:0]};

         s2_sign_ff <= s1_sign_ff;
         s2_nan_ff  <= s1_nan_ff;
         s2_inf_ff  <= s1_inf_ff;
         s2_isgn_ff <= s1_isgn_ff;
         s2_ea_ff   <= s1_ea_ff;
         s2_sum_ff  <= s2_sum_in;

         s3_sign_ff <= s2_sign_ff;
         s3_nan_ff  <= s2_nan_ff;
         s3_inf_ff  <= s2_inf_ff;
         s3_isgn_ff <= s2_isgn_ff;
         s3_sn_ff   <= sn_in;
         s3_e_ff    <= e_in;

         sum_bits   <= sum_in;
      end
   end

   assign out_valid = v_ff[STAGES-1];

endmodule

// ===== src/fpq_cvt.sv =====
// Output stage: binary32 to integer, ties to even, saturated to 0..255.
module fpq_cvt import fpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  stage_ctl_type     ctl,
   input  logic [FP_W-1:0]   in_bits,
   output logic [7:0]        quantized,
   output logic              out_valid
);

   logic        valid_ff;
   logic [7:0]  e;
   logic [3:0]  k;
   logic [31:0] w;
   logic [8:0]  rnd;
   logic [7:0]  q_in;

   assign e = in_bits[30:23];
   assign k = 4'(e - 8'd126);

   always_comb begin
      // value = w * 2^-24 for exponents 126..134
      w   = {8'd0, 1'b1, in_bits[22:0]} << k;
      rnd = {1'b0, w[31:24]} + {8'd0, w[23] & ((|w[22:0]) | w[24])};
      if (e == 8'hFF && in_bits[22:0] != 23'd0) begin
         q_in = 8'd0;
      end else if (in_bits[31]) begin
         q_in = 8'd0;
      end else if (e >= 8'd135) begin
         q_in = 8'd255;
      end else if (e < 8'd126) begin
         q_in = 8'd0;
      end else if (rnd[8]) begin
         q_in = 8'd255;
      end else begin
         q_in = rnd[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         quantized <= q_in;
      end
   end

   assign out_valid = valid_ff;

endmodule

// ===== src/fp32_to_uint8_affine_quantizer.sv =====
// Top level of the fp32 to uint8 affine quantizer.
// Each word is one binary32 sample; the result is round(sample*scale + bias) clamped to
// 0..255, with the product and the sum each rounded to nearest even in binary32, NaN
// giving 0. The datapath is a nine-stage pipeline (four for the multiplier, four for the
// adder, one for integer conversion) that takes one sample every cycle unless stalled.
// A result-side stall with a valid result freezes the pipeline while it lasts. Scale and
// bias are to be written through the csr port while idle; the block does not check it.
module fp32_to_uint8_affine_quantizer import fpq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FP_W-1:0]      req_sample_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_quantized,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FP_W-1:0]      csr_write_data
);

   logic [FP_W-1:0] scale_ff, scale_in, bias_ff, bias_in;
   logic            en;
   logic [FP_W-1:0] prod_bits, sum_bits;
   logic            mul_valid, add_valid;
   stage_ctl_type   mul_ctl, add_ctl, cvt_ctl;

   always_comb begin
      scale_in = scale_ff;
      bias_in  = bias_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE: scale_in = csr_write_data;
            CSR_BIAS:  bias_in  = csr_write_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         bias_ff  <= BIAS_RESET;
      end else begin
         scale_ff <= scale_in;
         bias_ff  <= bias_in;
      end
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = rsp_valid & rsp_stall;

   assign mul_ctl = '{en: en, valid: req_valid};
   assign add_ctl = '{en: en, valid: mul_valid};
   assign cvt_ctl = '{en: en, valid: add_valid};

   fpq_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mul_ctl),
      .a_bits    (req_sample_bits),
      .b_bits    (scale_ff),
      .prod_bits (prod_bits),
      .out_valid (mul_valid)
   );

   fpq_add u_add (
      .clock     (clock),
      .reset     (reset),
      .ctl       (add_ctl),
      .a_bits    (prod_bits),
      .b_bits    (bias_ff),
      .sum_bits  (sum_bits),
      .out_valid (add_valid)
   );

   fpq_cvt u_cvt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cvt_ctl),
      .in_bits   (sum_bits),
      .quantized (rsp_quantized),
      .out_valid (rsp_valid)
   );

endmodule
